FILE: sv/trcs_pkg.sv
// Package for the timed readout clock sequencer.
// Holds codes, default sizes, the controller state type and the
// command/status structs shared by the controller, datapath and top level.
`default_nettype none

package trcs_pkg;

    localparam int LIST_DEPTH_DEF = 64;
    localparam int TIME_BITS_DEF  = 48;
    localparam int INDEX_BITS_DEF = 10;
    localparam int FRAME_BITS     = 32;
    localparam int KIND_BITS      = 2;
    localparam int STATUS_BITS    = 2;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_STEP   = 1'b1;

    localparam logic [KIND_BITS-1:0] ENTRY_WAIT    = 2'd0;
    localparam logic [KIND_BITS-1:0] ENTRY_SHIFT   = 2'd1;
    localparam logic [KIND_BITS-1:0] ENTRY_READOUT = 2'd2;

    localparam logic [KIND_BITS-1:0] RES_NONE    = 2'd0;
    localparam logic [KIND_BITS-1:0] RES_WAIT    = 2'd1;
    localparam logic [KIND_BITS-1:0] RES_SHIFT   = 2'd2;
    localparam logic [KIND_BITS-1:0] RES_READOUT = 2'd3;

    localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_stat;

endpackage

`default_nettype wire

FILE: sv/trcs_ctrl.sv
// Controller state machine for the timed readout clock sequencer.
// Sequences accept, list read and execute; depends on trcs_pkg.
`default_nettype none

module trcs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire trcs_pkg::t_stat i_stat,
    output trcs_pkg::t_cmd     o_cmd
);
    import trcs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (!i_stat.out_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = i_rst_n;
                o_cmd.load = i_s_tvalid && i_rst_n;
            end
            ST_READ: begin
                o_cmd = '0;
            end
            ST_EXEC: begin
                o_cmd.exec = !i_stat.out_full;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_READ))
        else $error("load not followed by list read");
    a_exec_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_state == ST_IDLE))
        else $error("execute not followed by idle");
    a_no_exec_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.out_full |-> !o_cmd.exec)
        else $error("execute while output register occupied");
`endif

endmodule

`default_nettype wire

FILE: sv/trcs_dp.sv
// Datapath for the timed readout clock sequencer: request registers, list
// memory, position/time/frame state and the output register. Uses trcs_pkg.
`default_nettype none

module trcs_dp #(
    parameter int LIST_DEPTH = trcs_pkg::LIST_DEPTH_DEF,
    parameter int TIME_BITS  = trcs_pkg::TIME_BITS_DEF,
    parameter int INDEX_BITS = trcs_pkg::INDEX_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire trcs_pkg::t_cmd                      i_cmd,
    output trcs_pkg::t_stat                          o_stat,
    input  wire logic                                i_action,
    input  wire logic [trcs_pkg::KIND_BITS-1:0]      i_entry_kind,
    input  wire logic [TIME_BITS-1:0]                i_wait_duration,
    input  wire logic [INDEX_BITS-1:0]               i_line_index,
    input  wire logic [INDEX_BITS-1:0]               i_readout_index,
    input  wire logic [TIME_BITS-1:0]                i_query_time,
    input  wire logic                                i_m_tready,
    output logic                                     o_m_tvalid,
    output logic [trcs_pkg::KIND_BITS-1:0]           o_result_kind,
    output logic [INDEX_BITS-1:0]                    o_line_index_out,
    output logic [INDEX_BITS-1:0]                    o_readout_index_out,
    output logic [TIME_BITS-1:0]                     o_wait_duration_out,
    output logic [trcs_pkg::FRAME_BITS-1:0]          o_frame_number,
    output logic [trcs_pkg::STATUS_BITS-1:0]         o_status
);
    import trcs_pkg::*;

    localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int MW = KIND_BITS + TIME_BITS + 2 * INDEX_BITS;

    logic                   r_action;
    logic [KIND_BITS-1:0]   r_kind_in;
    logic [TIME_BITS-1:0]   r_dur_in;
    logic [INDEX_BITS-1:0]  r_line_in;
    logic [INDEX_BITS-1:0]  r_slot_in;
    logic [TIME_BITS-1:0]   r_qtime;

    logic [MW-1:0]          r_mem [LIST_DEPTH];
    logic [MW-1:0]          r_rd_word;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [PW-1:0]          r_pos;
    logic [PW-1:0]          n_pos;
    logic [TIME_BITS-1:0]   r_elapsed;
    logic [TIME_BITS-1:0]   n_elapsed;
    logic [FRAME_BITS-1:0]  r_frame;
    logic [FRAME_BITS-1:0]  n_frame;

    logic                   r_m_valid;
    logic [KIND_BITS-1:0]   r_out_kind;
    logic [KIND_BITS-1:0]   n_out_kind;
    logic [INDEX_BITS-1:0]  r_out_line;
    logic [INDEX_BITS-1:0]  n_out_line;
    logic [INDEX_BITS-1:0]  r_out_slot;
    logic [INDEX_BITS-1:0]  n_out_slot;
    logic [TIME_BITS-1:0]   r_out_dur;
    logic [TIME_BITS-1:0]   n_out_dur;
    logic [FRAME_BITS-1:0]  r_out_frame;
    logic [STATUS_BITS-1:0] r_out_status;
    logic [STATUS_BITS-1:0] n_out_status;

    logic [KIND_BITS-1:0]   rd_kind;
    logic [TIME_BITS-1:0]   rd_dur;
    logic [INDEX_BITS-1:0]  rd_line;
    logic [INDEX_BITS-1:0]  rd_slot;
    logic [TIME_BITS:0]     time_sum;
    logic                   waiting;
    logic [CW:0]            pos_inc;
    logic                   wrap;
    logic [PW-1:0]          adv_pos;
    logic [FRAME_BITS-1:0]  adv_frame;
    logic                   wr_en;

    assign {rd_kind, rd_dur, rd_line, rd_slot} = r_rd_word;

    assign time_sum  = {1'b0, r_elapsed} + {1'b0, rd_dur};
    assign waiting   = (time_sum >= {1'b0, r_qtime});
    assign pos_inc   = (CW + 1)'(r_pos) + (CW + 1)'(1);
    assign wrap      = (pos_inc >= {1'b0, r_count});
    assign adv_pos   = wrap ? '0 : pos_inc[PW-1:0];
    assign adv_frame = wrap ? r_frame + FRAME_BITS'(1) : r_frame;

    assign o_stat.out_full = r_m_valid && !i_m_tready;

    always_comb begin
        n_count      = r_count;
        n_pos        = r_pos;
        n_elapsed    = r_elapsed;
        n_frame      = r_frame;
        wr_en        = 1'b0;
        n_out_kind   = RES_NONE;
        n_out_line   = '0;
        n_out_slot   = '0;
        n_out_dur    = '0;
        n_out_status = STAT_OK;
        if (r_action == ACT_APPEND) begin
            if (r_kind_in <= ENTRY_READOUT) begin
                if (r_count >= CW'(LIST_DEPTH)) begin
                    n_out_status = STAT_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
        end else if (r_count == '0) begin
            n_out_status = STAT_EMPTY;
        end else begin
            case (rd_kind)
                ENTRY_WAIT: begin
                    if (!waiting) begin
                        n_out_kind = RES_WAIT;
                        n_out_dur  = rd_dur;
                        n_pos      = adv_pos;
                        n_frame    = adv_frame;
                        n_elapsed  = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];
                    end
                end
                ENTRY_SHIFT: begin
                    n_out_kind = RES_SHIFT;
                    n_pos      = adv_pos;
                    n_frame    = adv_frame;
                end
                default: begin
                    n_out_kind = RES_READOUT;
                    n_out_line = rd_line;
                    n_out_slot = rd_slot;
                    n_pos      = adv_pos;
                    n_frame    = adv_frame;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_kind_in <= i_entry_kind;
            r_dur_in  <= i_wait_duration;
            r_line_in <= i_line_index;
            r_slot_in <= i_readout_index;
            r_qtime   <= i_query_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[r_count[PW-1:0]] <= {r_kind_in, r_dur_in, r_line_in, r_slot_in};
        end
        r_rd_word <= r_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pos     <= '0;
            r_elapsed <= '0;
            r_frame   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_count   <= n_count;
                r_pos     <= n_pos;
                r_elapsed <= n_elapsed;
                r_frame   <= n_frame;
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_kind   <= n_out_kind;
            r_out_line   <= n_out_line;
            r_out_slot   <= n_out_slot;
            r_out_dur    <= n_out_dur;
            r_out_frame  <= n_frame;
            r_out_status <= n_out_status;
        end
    end

    assign o_m_tvalid          = r_m_valid;
    assign o_result_kind       = r_out_kind;
    assign o_line_index_out    = r_out_line;
    assign o_readout_index_out = r_out_slot;
    assign o_wait_duration_out = r_out_dur;
    assign o_frame_number      = r_out_frame;
    assign o_status            = r_out_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("entry count beyond list depth");
    a_pos_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW + 1)'(r_pos) < {1'b0, r_count} || (r_count == '0 && r_pos == '0))
        else $error("position outside filled list");
    a_elapsed_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_elapsed >= $past(r_elapsed))
        else $error("elapsed time decreased");
    a_frame_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_frame) && $stable(r_pos))
        else $error("frame or position moved without execute");
`endif

endmodule

`default_nettype wire

FILE: sv/timed_readout_clock_sequencer.sv
// Top level of the timed readout clock sequencer: stream ports, field
// packing, controller and datapath. Uses trcs_pkg, trcs_ctrl and trcs_dp.
//
//  channel  | direction | tdata / tuser contents
//  s (in)   | slave     | request: append entry or step at query time
//  m (out)  | master    | result: emitted entry, frame number, status
//
// Each request passes through three steps: accept, list memory read, execute.
// The registered read port of the list memory sets the middle step.
// Execute stalls while the output register holds a result not yet taken.
// i_rst_n (synchronous) empties the list and clears position, elapsed time
// and frame counter; list contents stay undefined and need no clearing pass.
`default_nettype none

module timed_readout_clock_sequencer #(
    parameter int LIST_DEPTH = trcs_pkg::LIST_DEPTH_DEF,
    parameter int TIME_BITS  = trcs_pkg::TIME_BITS_DEF,
    parameter int INDEX_BITS = trcs_pkg::INDEX_BITS_DEF,
    localparam int IN_W      = 2 * TIME_BITS + 2 * INDEX_BITS,
    localparam int IN_TW     = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W     = 2 * INDEX_BITS + TIME_BITS + trcs_pkg::FRAME_BITS,
    localparam int OUT_TW    = ((OUT_W + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // wait_duration, line_index, readout_index, query_time
    input  wire logic [IN_TW-1:0]  i_s_tdata,
    // action, entry_kind
    input  wire logic [7:0]        i_s_tuser,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // line_index_out, readout_index_out, wait_duration_out, frame_number
    output logic [OUT_TW-1:0]      o_m_tdata,
    // result_kind, status
    output logic [7:0]             o_m_tuser
);
    import trcs_pkg::*;

    localparam int LINE_LO = TIME_BITS;
    localparam int SLOT_LO = TIME_BITS + INDEX_BITS;
    localparam int QT_LO   = TIME_BITS + 2 * INDEX_BITS;

    t_cmd                   cmd;
    t_stat                  stat;
    logic [KIND_BITS-1:0]   result_kind;
    logic [INDEX_BITS-1:0]  line_out;
    logic [INDEX_BITS-1:0]  slot_out;
    logic [TIME_BITS-1:0]   dur_out;
    logic [FRAME_BITS-1:0]  frame_out;
    logic [STATUS_BITS-1:0] status_out;

    trcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    trcs_dp #(
        .LIST_DEPTH (LIST_DEPTH),
        .TIME_BITS  (TIME_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_action            (i_s_tuser[0]),
        .i_entry_kind        (i_s_tuser[KIND_BITS:1]),
        .i_wait_duration     (i_s_tdata[TIME_BITS-1:0]),
        .i_line_index        (i_s_tdata[LINE_LO +: INDEX_BITS]),
        .i_readout_index     (i_s_tdata[SLOT_LO +: INDEX_BITS]),
        .i_query_time        (i_s_tdata[QT_LO +: TIME_BITS]),
        .i_m_tready          (i_m_tready),
        .o_m_tvalid          (o_m_tvalid),
        .o_result_kind       (result_kind),
        .o_line_index_out    (line_out),
        .o_readout_index_out (slot_out),
        .o_wait_duration_out (dur_out),
        .o_frame_number      (frame_out),
        .o_status            (status_out)
    );

    assign o_m_tdata = OUT_TW'({frame_out, dur_out, slot_out, line_out});
    assign o_m_tuser = 8'({status_out, result_kind});

endmodule

`default_nettype wire
